@@ rtl/core/motion_window_cycle_detector_defines.svh @@
// Assertion macros for the motion window cycle detector checker.
// Depends on nothing; included by the checker file by its bare name.
`ifndef MOTION_WINDOW_CYCLE_DETECTOR_DEFINES_SVH
`define MOTION_WINDOW_CYCLE_DETECTOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MWCD_ASSERT_SAME(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("motion window cycle detector: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MWCD_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("motion window cycle detector: next-cycle check failed");

`endif

@@ rtl/core/mwcd_pkg.sv @@
// Shared types, constants and register codes for the motion window cycle detector.
// Depends on nothing; imported by every module of the block.
`timescale 1ns / 1ps

package mwcd_pkg;

    localparam int WINDOW_LEN       = 60;
    localparam int CNT_W            = $clog2(WINDOW_LEN + 1);
    localparam int CFG_COUNT_W      = 6;
    localparam int CMP_W            = (CNT_W > CFG_COUNT_W) ? CNT_W : CFG_COUNT_W;
    localparam int MOTION_COUNT_MAX = 63;

    localparam int MAG_W        = 16;
    localparam int INTERVAL_W   = 16;
    localparam int NOTIFY_CNT_W = 4;
    localparam int PHASE_W      = 2;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 16;

    typedef logic [CNT_W-1:0]        count_t;
    typedef logic [MAG_W-1:0]        mag_t;
    typedef logic [INTERVAL_W-1:0]   interval_t;
    typedef logic [NOTIFY_CNT_W-1:0] notify_cnt_t;
    typedef logic [CFG_COUNT_W-1:0]  cfg_count_t;
    typedef logic [PHASE_W-1:0]      phase_code_t;
    typedef logic [CFG_ADDR_W-1:0]   cfg_addr_t;
    typedef logic [CFG_DATA_W-1:0]   cfg_data_t;

    // Phase codes as they appear on the result.
    localparam phase_code_t PHASE_START = 2'd0;
    localparam phase_code_t PHASE_WASH  = 2'd1;
    localparam phase_code_t PHASE_DOOR  = 2'd2;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_REFERENCE_MAGNITUDE = 3'd0,
        REG_MOTION_THRESHOLD    = 3'd1,
        REG_START_COUNT         = 3'd2,
        REG_STOP_COUNT          = 3'd3,
        REG_DOOR_COUNT          = 3'd4,
        REG_NOTIFY_INTERVAL     = 3'd5,
        REG_MAX_NOTIFICATIONS   = 3'd6
    } cfg_reg_t;

    // Register reset values.
    localparam mag_t        RST_REFERENCE_MAGNITUDE = 16'd0;
    localparam mag_t        RST_MOTION_THRESHOLD    = 16'd10;
    localparam cfg_count_t  RST_START_COUNT         = 6'd45;
    localparam cfg_count_t  RST_STOP_COUNT          = 6'd10;
    localparam cfg_count_t  RST_DOOR_COUNT          = 6'd10;
    localparam interval_t   RST_NOTIFY_INTERVAL     = 16'd60;
    localparam notify_cnt_t RST_MAX_NOTIFICATIONS   = 4'd5;

    typedef struct packed {
        mag_t        reference_magnitude;
        mag_t        motion_threshold;
        cfg_count_t  start_count;
        cfg_count_t  stop_count;
        cfg_count_t  door_count;
        interval_t   notify_interval;
        notify_cnt_t max_notifications;
    } cfg_t;

    // Control for one window update: shift a bit in, then optionally fill or clear.
    typedef struct packed {
        logic shift;
        logic bit_in;
        logic fill;
        logic clear;
    } win_ctrl_t;

endpackage

@@ rtl/core/mwcd_cfg_regs.sv @@
// Configuration register file of the motion window cycle detector.
// Depends on mwcd_pkg for the register codes, reset values and the cfg_t bundle.
`timescale 1ns / 1ps

module mwcd_cfg_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  mwcd_pkg::cfg_addr_t cfg_index,
    input  mwcd_pkg::cfg_data_t cfg_data,
    output mwcd_pkg::cfg_t     cfg
);
    import mwcd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Every write is taken at once.
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_REFERENCE_MAGNITUDE: cfg_next.reference_magnitude = cfg_data;
                REG_MOTION_THRESHOLD:    cfg_next.motion_threshold    = cfg_data;
                REG_START_COUNT:         cfg_next.start_count = cfg_data[CFG_COUNT_W-1:0];
                REG_STOP_COUNT:          cfg_next.stop_count  = cfg_data[CFG_COUNT_W-1:0];
                REG_DOOR_COUNT:          cfg_next.door_count  = cfg_data[CFG_COUNT_W-1:0];
                REG_NOTIFY_INTERVAL:     cfg_next.notify_interval     = cfg_data;
                REG_MAX_NOTIFICATIONS:
                    cfg_next.max_notifications = cfg_data[NOTIFY_CNT_W-1:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reference_magnitude <= RST_REFERENCE_MAGNITUDE;
            cfg_reg.motion_threshold    <= RST_MOTION_THRESHOLD;
            cfg_reg.start_count         <= RST_START_COUNT;
            cfg_reg.stop_count          <= RST_STOP_COUNT;
            cfg_reg.door_count          <= RST_DOOR_COUNT;
            cfg_reg.notify_interval     <= RST_NOTIFY_INTERVAL;
            cfg_reg.max_notifications   <= RST_MAX_NOTIFICATIONS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/core/mwcd_window.sv @@
// Motion window shift register with a running count of its ones.
// Depends on mwcd_pkg for the window length, count type and control bundle.
`timescale 1ns / 1ps

module mwcd_window (
    input  logic                clk,
    input  logic                rst_n,
    input  mwcd_pkg::win_ctrl_t ctrl,
    output mwcd_pkg::count_t    count_shift
);
    import mwcd_pkg::*;

    logic [WINDOW_LEN-1:0] window_reg;
    logic [WINDOW_LEN-1:0] window_next;
    count_t                count_reg;
    count_t                count_next;
    logic                  oldest;

    // The newest bit enters at the bottom; the oldest leaves from the top.
    assign oldest      = window_reg[WINDOW_LEN-1];
    assign count_shift = count_t'(count_reg + count_t'(ctrl.bit_in) - count_t'(oldest));

    always_comb
    begin
        window_next = window_reg;
        count_next  = count_reg;
        if (ctrl.shift)
        begin
            if (ctrl.fill)
            begin
                window_next = '1;
                count_next  = count_t'(WINDOW_LEN);
            end
            else if (ctrl.clear)
            begin
                window_next = '0;
                count_next  = '0;
            end
            else
            begin
                window_next = {window_reg[WINDOW_LEN-2:0], ctrl.bit_in};
                count_next  = count_shift;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            window_reg <= window_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/core/motion_window_cycle_detector.sv @@
// Top level of the motion window cycle detector: input stage, phase machine, result stage.
// Depends on mwcd_pkg, mwcd_cfg_regs and mwcd_window.
`timescale 1ns / 1ps

// Usage.
// Each input request carries one magnitude sample (one per one-second tick) on the
// in_valid / in_stall channel; it is taken at a rising edge with in_valid high and
// in_stall low. Each request yields exactly one result request on out_valid /
// out_stall holding phase, motion, motion_count, notify and notifications_sent.
// The sample is captured in an input register; once the result register is free or is
// being emptied, the motion test, the running window count, the phase machine and the
// notification timer are evaluated in one pass and written into the result register,
// which drives out_valid. Throughput is one request per cycle while out_stall stays
// low, set by that single pass; the running count avoids summing the whole window.
// When the receiver raises out_stall the result is held unchanged; the input
// register still takes one more request, and in_stall rises only once both the
// input register and the result register are full.
// Configuration writes (cfg_valid / cfg_ready, always ready) are applied at once
// and are meant to be issued only while the block is idle.
// Reset clears the window, puts the machine in the awaiting start phase, zeroes the
// tick and notification counters, empties both stages and loads the register
// defaults.
module motion_window_cycle_detector (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  mwcd_pkg::mag_t           magnitude,
    output logic                     out_valid,
    input  logic                     out_stall,
    output mwcd_pkg::phase_code_t    phase,
    output logic                     motion,
    output mwcd_pkg::cfg_count_t     motion_count,
    output logic                     notify,
    output mwcd_pkg::notify_cnt_t    notifications_sent,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  mwcd_pkg::cfg_addr_t      cfg_index,
    input  mwcd_pkg::cfg_data_t      cfg_data
);
    import mwcd_pkg::*;

    // Phase machine states, one-hot.
    typedef enum logic [2:0] {
        ST_START = 3'b001,
        ST_WASH  = 3'b010,
        ST_DOOR  = 3'b100
    } phase_state_t;

    cfg_t cfg;

    // Input stage.
    logic  in_valid_reg;
    logic  in_valid_next;
    mag_t  mag_reg;
    logic  in_accept;
    logic  advance;

    // Result stage.
    logic        out_valid_reg;
    logic        out_valid_next;
    phase_code_t out_phase_reg;
    logic        out_motion_reg;
    cfg_count_t  out_count_reg;
    logic        out_notify_reg;
    notify_cnt_t out_sent_reg;

    // Block state.
    phase_state_t phase_reg;
    phase_state_t phase_next;
    interval_t    elapsed_reg;
    interval_t    elapsed_next;
    notify_cnt_t  sent_reg;
    notify_cnt_t  sent_next;

    // Per-tick datapath.
    mag_t        diff;
    logic        motion_bit;
    count_t      count_shift;
    logic [CMP_W-1:0] count_cmp;
    interval_t   elapsed_inc;
    logic        notify_hit;
    logic        notify_bit;
    logic        win_fill;
    logic        win_clear;
    phase_code_t phase_code;
    cfg_count_t  count_out;
    win_ctrl_t   win_ctrl;

    mwcd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // The sample in the input register moves on whenever the result register is
    // free or is being emptied in this cycle.
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && out_valid_reg && out_stall;
    assign in_accept = in_valid && !in_stall;

    assign in_valid_next  = in_accept || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);

    // Motion test on the absolute distance from the reference.
    assign diff = (mag_reg >= cfg.reference_magnitude) ?
                  mag_t'(mag_reg - cfg.reference_magnitude) :
                  mag_t'(cfg.reference_magnitude - mag_reg);
    assign motion_bit = (diff >= cfg.motion_threshold);

    assign win_ctrl.shift  = advance;
    assign win_ctrl.bit_in = motion_bit;
    assign win_ctrl.fill   = win_fill;
    assign win_ctrl.clear  = win_clear;

    mwcd_window u_window (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (win_ctrl),
        .count_shift (count_shift)
    );

    assign count_cmp = CMP_W'(count_shift);

    // The tick counter saturates rather than wrapping.
    assign elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : interval_t'(elapsed_reg + 1'b1);
    assign notify_hit  = (elapsed_inc >= cfg.notify_interval) &&
                         (sent_reg < cfg.max_notifications);

    // At most one transition per tick. The window fill or clear applies after the
    // sample has been shifted in, so the reported count is the shifted count.
    always_comb
    begin
        phase_next   = phase_reg;
        elapsed_next = elapsed_reg;
        sent_next    = sent_reg;
        notify_bit   = 1'b0;
        win_fill     = 1'b0;
        win_clear    = 1'b0;
        case (phase_reg)
            ST_WASH:
            begin
                if (count_cmp <= CMP_W'(cfg.stop_count))
                begin
                    phase_next   = ST_DOOR;
                    elapsed_next = '0;
                    win_clear    = 1'b1;
                end
            end
            ST_DOOR:
            begin
                // The timer and the notification are settled before the exit test.
                elapsed_next = elapsed_inc;
                if (notify_hit)
                begin
                    notify_bit   = 1'b1;
                    elapsed_next = '0;
                    sent_next    = notify_cnt_t'(sent_reg + 1'b1);
                end
                if (count_cmp >= CMP_W'(cfg.door_count))
                begin
                    phase_next   = ST_START;
                    elapsed_next = '0;
                    sent_next    = '0;
                    win_clear    = 1'b1;
                end
            end
            default:
            begin
                // Awaiting start.
                phase_next = ST_START;
                if (count_cmp >= CMP_W'(cfg.start_count))
                begin
                    phase_next = ST_WASH;
                    win_fill   = 1'b1;
                end
            end
        endcase
    end

    always_comb
    begin
        case (phase_next)
            ST_WASH: phase_code = PHASE_WASH;
            ST_DOOR: phase_code = PHASE_DOOR;
            default: phase_code = PHASE_START;
        endcase
    end

    // The reported count saturates when the window is longer than the field allows.
    assign count_out = (count_cmp > CMP_W'(MOTION_COUNT_MAX)) ?
                       cfg_count_t'(MOTION_COUNT_MAX) : count_cmp[CFG_COUNT_W-1:0];

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= ST_START;
            elapsed_reg   <= '0;
            sent_reg      <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                phase_reg   <= phase_next;
                elapsed_reg <= elapsed_next;
                sent_reg    <= sent_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            mag_reg <= magnitude;
        end
        if (advance)
        begin
            out_phase_reg  <= phase_code;
            out_motion_reg <= motion_bit;
            out_count_reg  <= count_out;
            out_notify_reg <= notify_bit;
            out_sent_reg   <= sent_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign phase              = out_phase_reg;
    assign motion             = out_motion_reg;
    assign motion_count       = out_count_reg;
    assign notify             = out_notify_reg;
    assign notifications_sent = out_sent_reg;

endmodule

@@ rtl/core/mwcd_checker.sv @@
// Port-level checker for the motion window cycle detector, bound to the top level.
// Depends on mwcd_pkg and the macros in motion_window_cycle_detector_defines.svh.
`timescale 1ns / 1ps
`include "motion_window_cycle_detector_defines.svh"

module mwcd_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_stall,
    input logic                  out_valid,
    input logic                  out_stall,
    input mwcd_pkg::phase_code_t phase,
    input logic                  motion,
    input mwcd_pkg::cfg_count_t  motion_count,
    input logic                  notify,
    input mwcd_pkg::notify_cnt_t notifications_sent
);
    import mwcd_pkg::*;

    // A stalled result keeps its fields.
    `MWCD_ASSERT_NEXT(a_result_held, clk, rst_n, out_valid && out_stall,
        out_valid && $stable(phase) && $stable(motion) && $stable(motion_count) &&
        $stable(notify) && $stable(notifications_sent))

    // The input side only backs up when the result side is full and stalled.
    `MWCD_ASSERT_SAME(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

    // Notifications are counted only while awaiting the door.
    `MWCD_ASSERT_SAME(a_sent_zero_outside_door, clk, rst_n,
        out_valid && (phase != PHASE_DOOR), notifications_sent == '0)

    // A notification either leaves a non-zero count in the door phase or ends the cycle.
    `MWCD_ASSERT_SAME(a_notify_phase, clk, rst_n, out_valid && notify,
        ((phase == PHASE_DOOR) && (notifications_sent != '0)) || (phase == PHASE_START))

endmodule

bind motion_window_cycle_detector mwcd_checker u_mwcd_checker (.*);
